### rtl/core/bhp_pkg.sv
// ----------------------------------------------------------------------------
// bhp_pkg
// Shared types, widths and codes of the bucket histogram percent unit.
// ----------------------------------------------------------------------------
package bhp_pkg;

  localparam int NUM_BUCKETS = 8;
  localparam int NUM_LIMITS  = 7;

  localparam int CNT_W     = 32;
  localparam int IDX_W     = 3;
  localparam int PCT_W     = 7;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int LIM_IDX_W = 3;

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int TOT_W  = CNT_W + BKT_W;
  localparam int QUO_W  = PCT_W;
  localparam int NUM_W  = CNT_W + PCT_W;
  localparam int DEN_W  = TOT_W + QUO_W - 1;
  localparam int CMP_W  = (DEN_W > NUM_W) ? DEN_W : NUM_W;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [STAT_W-1:0] STAT_COUNTED  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_CLEARED  = 2'd2;

  typedef logic [CNT_W-1:0] limit_arr_t [NUM_LIMITS];

  localparam limit_arr_t LIMIT_RESET = '{
    32'd1, 32'd2, 32'd4, 32'd8, 32'd16, 32'd32, 32'd64
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIN,
    ST_RDT,
    ST_UPD,
    ST_RD,
    ST_MUL,
    ST_DIV,
    ST_PUT
  } state_e;

endpackage

### rtl/core/bhp_if.sv
// ----------------------------------------------------------------------------
// bhp_in_if / bhp_out_if
// Valid/ready channels for the input items and the bucket results.
// ----------------------------------------------------------------------------
interface bhp_in_if import bhp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [CNT_W-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface bhp_out_if import bhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  bucket_index;
  logic [CNT_W-1:0]  bucket_count;
  logic [PCT_W-1:0]  bucket_percent;
  logic [STAT_W-1:0] status;
  logic              last_of_run;

  modport source (
    output valid, output bucket_index, output bucket_count,
    output bucket_percent, output status, output last_of_run, input ready
  );
  modport sink (
    input valid, input bucket_index, input bucket_count,
    input bucket_percent, input status, input last_of_run, output ready
  );
endinterface

### rtl/core/bucket_histogram_percent_unit.sv
// ----------------------------------------------------------------------------
// bucket_histogram_percent_unit
// An item is taken only in the idle state and then emits one result per bucket.
// A clear or a rejected sample keeps the unit busy until all bucket results are out,
// an add also for binning (one limit compare per cycle) and the update.
// Each bucket runs memory read, multiply, 7-step divide, load; the load waits for a free output.
// Reset clears all counts at once through per-entry valid flags and loads
// the default limits; there is no clearing pass.
// ----------------------------------------------------------------------------
module bucket_histogram_percent_unit import bhp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  bhp_in_if.sink               in_i,
  bhp_out_if.source            out_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]     limit_q [NUM_LIMITS];
  logic [NUM_BUCKETS-1:0] vld_q, vld_d;
  logic [CNT_W-1:0]     cnt_mem [NUM_BUCKETS];
  logic [CNT_W-1:0]     rd_data_q;
  logic                 rd_vld_q;

  logic [LIM_IDX_W-1:0] idx_q, idx_d;
  logic [BKT_W-1:0]     tgt_q, tgt_d;
  logic [BKT_W-1:0]     bkt_q, bkt_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [STAT_W-1:0]    status_q, status_d;
  logic [CNT_W-1:0]     sample_q, sample_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [TOT_W-1:0]     total_q, total_d;

  logic                 out_vld_q, out_vld_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;
  logic [CNT_W-1:0]     out_cnt_q, out_cnt_d;
  logic [PCT_W-1:0]     out_pct_q, out_pct_d;
  logic [STAT_W-1:0]    out_stat_q, out_stat_d;
  logic                 out_last_q, out_last_d;

  logic                 mem_we, mem_re;
  logic [BKT_W-1:0]     mem_waddr, mem_raddr;
  logic [CNT_W-1:0]     mem_wdata;

  logic                 in_fire, out_fire, out_free;
  logic                 hit, fits, last_bkt, last_lim, step_done;
  logic [CNT_W-1:0]     cur;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_fire  = out_o.valid && out_o.ready;
  assign out_free  = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign hit       = (sample_q <= limit_q[idx_q]);
  assign last_lim  = (idx_q == LIM_IDX_W'(NUM_BUCKETS - 2));
  assign last_bkt  = (bkt_q == BKT_W'(NUM_BUCKETS - 1));
  assign step_done = (step_q == '0);
  assign cur       = rd_vld_q ? rd_data_q : '0;
  assign fits      = (CMP_W'(num_q) >= CMP_W'(den_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == OP_ADD && in_i.sample != '0) begin
            state_d = ST_BIN;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_BIN: begin
        if (hit || last_lim) begin
          state_d = ST_RDT;
        end
      end
      ST_RDT: state_d = ST_UPD;
      ST_UPD: state_d = ST_RD;
      ST_RD:  state_d = ST_MUL;
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (step_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          state_d = last_bkt ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d      = idx_q;
    tgt_d      = tgt_q;
    bkt_d      = bkt_q;
    step_d     = step_q;
    status_d   = status_q;
    sample_d   = sample_q;
    cnt_d      = cnt_q;
    num_d      = num_q;
    den_d      = den_q;
    quo_d      = quo_q;
    total_d    = total_q;
    vld_d      = vld_q;
    out_vld_d  = out_fire ? 1'b0 : out_vld_q;
    out_idx_d  = out_idx_q;
    out_cnt_d  = out_cnt_q;
    out_pct_d  = out_pct_q;
    out_stat_d = out_stat_q;
    out_last_d = out_last_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = tgt_q;
    mem_raddr  = bkt_q;
    mem_wdata  = cur + CNT_W'(1);
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sample_d = in_i.sample;
          idx_d    = '0;
          bkt_d    = '0;
          if (in_i.opcode == OP_CLEAR) begin
            status_d = STAT_CLEARED;
            vld_d    = '0;
            total_d  = '0;
          end else if (in_i.sample == '0) begin
            status_d = STAT_REJECTED;
          end else begin
            status_d = STAT_COUNTED;
          end
        end
      end
      ST_BIN: begin
        if (hit) begin
          tgt_d = BKT_W'(idx_q);
        end else if (last_lim) begin
          tgt_d = BKT_W'(NUM_BUCKETS - 1);
        end else begin
          idx_d = idx_q + LIM_IDX_W'(1);
        end
      end
      ST_RDT: begin
        mem_re    = 1'b1;
        mem_raddr = tgt_q;
      end
      ST_UPD: begin
        if (cur != CNT_MAX) begin
          mem_we       = 1'b1;
          vld_d[tgt_q] = 1'b1;
          total_d      = total_q + TOT_W'(1);
        end
      end
      ST_RD: begin
        mem_re = 1'b1;
      end
      ST_MUL: begin
        cnt_d  = cur;
        num_d  = NUM_W'(cur) * NUM_W'(PCT_SCALE);
        den_d  = DEN_W'(total_q) << (QUO_W - 1);
        step_d = STEP_W'(QUO_W - 1);
        quo_d  = '0;
      end
      ST_DIV: begin
        if (fits) begin
          num_d = num_q - NUM_W'(den_q);
        end
        den_d  = den_q >> 1;
        quo_d  = {quo_q[QUO_W-2:0], fits};
        step_d = step_q - STEP_W'(1);
      end
      ST_PUT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_idx_d  = IDX_W'(bkt_q);
          out_cnt_d  = cnt_q;
          out_pct_d  = (total_q == '0) ? '0 : quo_q;
          out_stat_d = status_q;
          out_last_d = last_bkt;
          bkt_d      = bkt_q + BKT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= cnt_mem[mem_raddr];
      rd_vld_q  <= vld_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      total_q   <= '0;
      out_vld_q <= 1'b0;
      limit_q   <= LIMIT_RESET;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      total_q   <= total_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i && cfg_index_i < CFG_IDX_W'(NUM_LIMITS)) begin
        limit_q[cfg_index_i[LIM_IDX_W-1:0]] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_d_reg: begin
      idx_q      <= idx_d;
      tgt_q      <= tgt_d;
      bkt_q      <= bkt_d;
      step_q     <= step_d;
      status_q   <= status_d;
      sample_q   <= sample_d;
      cnt_q      <= cnt_d;
      num_q      <= num_d;
      den_q      <= den_d;
      quo_q      <= quo_d;
      out_idx_q  <= out_idx_d;
      out_cnt_q  <= out_cnt_d;
      out_pct_q  <= out_pct_d;
      out_stat_q <= out_stat_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.bucket_index   = out_idx_q;
  assign out_o.bucket_count   = out_cnt_q;
  assign out_o.bucket_percent = out_pct_q;
  assign out_o.status         = out_stat_q;
  assign out_o.last_of_run    = out_last_q;

`ifndef SYNTH
  a_clear_zeroes_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.opcode == OP_CLEAR |=> total_q == '0)
    else $error("total not zero after a clear transaction");

  a_last_is_top_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_o.last_of_run |-> out_o.bucket_index == IDX_W'(NUM_BUCKETS - 1))
    else $error("last_of_run on a bucket other than the last");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.bucket_percent <= PCT_SCALE)
    else $error("bucket_percent above 100");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input taken again before the previous item finished");
`endif

endmodule

### tb/tb_bucket_histogram_percent_unit.sv
// ----------------------------------------------------------------------------
// tb_bucket_histogram_percent_unit
// Self-checking testbench for the bucket histogram percent unit. Add and
// clear transactions are sent over the input channel while a scoreboard
// tracks the bucket limits and counts and predicts all eight bucket reports
// per transaction. Each report is compared field by field. Directed tests
// cover the default limits, extreme and unordered limits and an unused
// register index. They are followed by random traffic under several
// handshake idle patterns.
// ----------------------------------------------------------------------------
module tb_bucket_histogram_percent_unit;
  import bhp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum int {LIM_SORTED, LIM_WIDE, LIM_SCATTER} limit_mode_e;

  typedef struct {
    logic [IDX_W-1:0]  bkt_idx;
    logic [CNT_W-1:0]  count;
    logic [PCT_W-1:0]  pct;
    logic [STAT_W-1:0] stat;
    logic              last;
  } bucket_report_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CNT_W-1:0]     cfg_data_i;

  bhp_in_if  in_if ();
  bhp_out_if out_if ();

  bucket_histogram_percent_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  logic [CNT_W-1:0] limit_model [NUM_LIMITS];
  logic [CNT_W-1:0] count_model [NUM_BUCKETS];
  bucket_report_t   report_q [$];
  bucket_report_t   seen_rep;
  int               error_count = 0;
  int               cycle_count = 0;
  int               send_idle_pct = 22;
  int               recv_idle_pct = 82;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void bin_and_report(input logic op, input logic [CNT_W-1:0] smp);
    logic [STAT_W-1:0] stat;
    logic [63:0]       total;
    logic [63:0]       scaled;
    int                target;
    int                i;
    bucket_report_t    rep;
    if (op == OP_CLEAR) begin
      for (i = 0; i < NUM_BUCKETS; i++) count_model[i] = '0;
      stat = STAT_CLEARED;
    end else if (smp == '0) begin
      stat = STAT_REJECTED;
    end else begin
      target = NUM_BUCKETS - 1;
      for (i = NUM_BUCKETS - 2; i >= 0; i--) begin
        if (smp <= limit_model[i]) target = i;
      end
      if (count_model[target] != CNT_MAX) count_model[target] = count_model[target] + 1;
      stat = STAT_COUNTED;
    end
    total = '0;
    for (i = 0; i < NUM_BUCKETS; i++) total = total + count_model[i];
    for (i = 0; i < NUM_BUCKETS; i++) begin
      scaled = count_model[i];
      scaled = scaled * PCT_SCALE;
      rep.bkt_idx = i[IDX_W-1:0];
      rep.count   = count_model[i];
      rep.pct     = (total == 0) ? '0 : PCT_W'(scaled / total);
      rep.stat    = stat;
      rep.last    = (i == NUM_BUCKETS - 1);
      report_q.push_back(rep);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_val,
                                      input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report: expected none, actual bucket %0d count %0d",
                 $time, out_if.bucket_index, out_if.bucket_count);
        error_count++;
      end else begin
        seen_rep = report_q.pop_front();
        check_field("bucket_index", seen_rep.bkt_idx, out_if.bucket_index);
        check_field("bucket_count", seen_rep.count, out_if.bucket_count);
        check_field("bucket_percent", seen_rep.pct, out_if.bucket_percent);
        check_field("status", seen_rep.stat, out_if.status);
        check_field("last_of_run", seen_rep.last, out_if.last_of_run);
      end
    end
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(input logic op, input logic [CNT_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.sample <= smp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bin_and_report(op, smp);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    if (idx < NUM_LIMITS) limit_model[idx] = val;
  endtask

  task automatic program_limits(input logic [CNT_W-1:0] vals [NUM_LIMITS]);
    int i;
    drain();
    for (i = 0; i < NUM_LIMITS; i++) cfg_write(i[CFG_IDX_W-1:0], vals[i]);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_default_limits();
    send_item(OP_ADD, 32'd0);
    send_item(OP_CLEAR, 32'hFFFF_FFFF);
    send_item(OP_ADD, 32'd1);
    send_item(OP_ADD, 32'd2);
    send_item(OP_ADD, 32'd3);
    send_item(OP_ADD, 32'd5);
    send_item(OP_ADD, 32'd8);
    send_item(OP_ADD, 32'd17);
    send_item(OP_ADD, 32'd33);
    send_item(OP_ADD, 32'd64);
    send_item(OP_ADD, 32'd65);
    send_item(OP_ADD, 32'hFFFF_FFFF);
    send_item(OP_ADD, 32'h8000_0000);
    send_item(OP_ADD, 32'd0);
    send_item(OP_CLEAR, 32'h5555_5555);
    send_item(OP_ADD, 32'd4);
  endtask

  task automatic test_extreme_limits();
    logic [CNT_W-1:0] vals [NUM_LIMITS];
    foreach (vals[i]) vals[i] = '1;
    program_limits(vals);
    send_item(OP_ADD, 32'd1);
    send_item(OP_ADD, 32'hFFFF_FFFF);
    foreach (vals[i]) vals[i] = '0;
    program_limits(vals);
    send_item(OP_ADD, 32'd1);
    send_item(OP_ADD, 32'hFFFF_FFFF);
  endtask

  task automatic test_unordered_limits();
    logic [CNT_W-1:0] vals [NUM_LIMITS];
    vals = '{32'd100, 32'd10, 32'd50, 32'd5, 32'd1000, 32'd2, 32'd7};
    program_limits(vals);
    send_item(OP_CLEAR, 32'hAAAA_AAAA);
    send_item(OP_ADD, 32'd7);
    send_item(OP_ADD, 32'd101);
    send_item(OP_ADD, 32'd1001);
  endtask

  task automatic test_unused_index();
    drain();
    cfg_write(CFG_IDX_W'(NUM_LIMITS), 32'd0);
    cfg_we_i <= 1'b0;
    send_item(OP_ADD, 32'd1);
    send_item(OP_ADD, 32'd100);
  endtask

  task automatic test_random_traffic(input int n_items, input limit_mode_e mode,
                                     input int snd_pct, input int rcv_pct);
    logic [CNT_W-1:0] vals [NUM_LIMITS];
    logic [CNT_W-1:0] smp;
    logic [CNT_W-1:0] acc;
    int               pick;
    int               k;
    acc = '0;
    foreach (vals[i]) begin
      case (mode)
        LIM_SORTED: begin
          acc = acc + 32'($urandom_range(1, 40));
          vals[i] = acc;
        end
        LIM_WIDE:    vals[i] = $urandom;
        default:     vals[i] = 32'($urandom_range(0, 300));
      endcase
    end
    program_limits(vals);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(OP_CLEAR, $urandom);
      end else if (pick < 14) begin
        send_item(OP_ADD, 32'd0);
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          smp = limit_model[$urandom_range(NUM_LIMITS - 1)];
          smp = smp + 32'($urandom_range(2)) - 32'd1;
        end else if (pick < 75) begin
          smp = 32'($urandom_range(1, 400));
        end else begin
          smp = $urandom;
        end
        send_item(OP_ADD, smp);
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    in_if.valid  <= 1'b0;
    in_if.opcode <= OP_ADD;
    in_if.sample <= '0;
    limit_model  = LIMIT_RESET;
    foreach (count_model[i]) count_model[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_limits();
    test_extreme_limits();
    test_unordered_limits();
    test_unused_index();
    test_random_traffic(25, LIM_SORTED, 22, 82);
    test_random_traffic(25, LIM_WIDE, 82, 22);
    test_random_traffic(25, LIM_SCATTER, 0, 0);
    drain();

    if (error_count == 0 && report_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
